// ===== hdl/twn_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the text whitespace normalizer
// no dependencies

package twn_pkg;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // pending newline bound and counter width
  localparam int unsigned NL_W = 6;
  localparam logic [NL_W-1:0] NL_MAX = NL_W'(32);

  // command queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_in;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       end_of_output;
  } out_t;

  // one queued job: end marker, or a visible byte with its prefix
  typedef struct packed {
    logic            is_end;
    logic            space;
    logic [NL_W-1:0] nl_count;
    logic [7:0]      byte_val;
  } cmd_t;

  // queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ===== hdl/twn_front.sv =====
`timescale 1ns / 1ps
// front part: accepts input bytes, tracks whitespace state, queues jobs
// depends on twn_pkg

module twn_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  twn_pkg::in_t    in_data,
  input  twn_pkg::q_stat_t q_stat,
  output logic            push,
  output twn_pkg::cmd_t   push_cmd
);

  logic            after_space;
  logic            after_newline;
  logic            space_pending;
  logic [twn_pkg::NL_W-1:0] newlines_pending;

  logic accept;
  logic is_skip;
  logic is_nl;
  logic is_sp;
  logic is_vis;

  // classify the incoming byte
  always_comb begin
    is_skip = (in_data.byte_in == twn_pkg::CH_NUL) || (in_data.byte_in == twn_pkg::CH_CR);
    is_nl   = (in_data.byte_in == twn_pkg::CH_LF);
    is_sp   = (in_data.byte_in == twn_pkg::CH_SPACE) || (in_data.byte_in == twn_pkg::CH_TAB) ||
              (in_data.byte_in == twn_pkg::CH_FF) || (in_data.byte_in == twn_pkg::CH_VT);
    is_vis  = !is_skip && !is_nl && !is_sp;
  end

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // job for the back part
  assign push = accept && ((in_data.operation == twn_pkg::OP_END) || is_vis);
  always_comb begin
    push_cmd.is_end   = (in_data.operation == twn_pkg::OP_END);
    push_cmd.space    = space_pending;
    push_cmd.nl_count = newlines_pending;
    push_cmd.byte_val = in_data.byte_in;
  end

  // whitespace state
  always_ff @(posedge clk) begin
    if (rst) begin
      after_space      <= 1'b1;
      after_newline    <= 1'b0;
      space_pending    <= 1'b0;
      newlines_pending <= '0;
    end else if (accept) begin
      if (in_data.operation == twn_pkg::OP_END) begin
        after_space      <= 1'b1;
        after_newline    <= 1'b0;
        space_pending    <= 1'b0;
        newlines_pending <= '0;
      end else if (is_nl) begin
        space_pending <= 1'b0;
        if (!after_newline && (newlines_pending < twn_pkg::NL_MAX)) begin
          newlines_pending <= newlines_pending + 1'b1;
        end
        after_space   <= 1'b1;
        after_newline <= 1'b1;
      end else if (is_sp) begin
        after_newline <= 1'b0;
        if (!after_space) begin
          space_pending <= 1'b1;
          after_space   <= 1'b1;
        end
      end else if (is_vis) begin
        after_newline    <= 1'b0;
        after_space      <= 1'b0;
        space_pending    <= 1'b0;
        newlines_pending <= '0;
      end
    end
  end

endmodule

// ===== hdl/twn_queue.sv =====
`timescale 1ns / 1ps
// short job queue between front and back parts
// depends on twn_pkg

module twn_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  twn_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output twn_pkg::cmd_t    head,
  output twn_pkg::q_stat_t stat
);

  twn_pkg::cmd_t        entries [twn_pkg::QDEPTH];
  logic [twn_pkg::QAW-1:0] wr_ptr;
  logic [twn_pkg::QAW-1:0] rd_ptr;
  logic [twn_pkg::QAW:0]   count;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == (twn_pkg::QAW+1)'(twn_pkg::QDEPTH));
  assign head       = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/twn_back.sv =====
`timescale 1ns / 1ps
// back part: expands each queued job into output transfers
// depends on twn_pkg

module twn_back (
  input  logic             clk,
  input  logic             rst,
  input  twn_pkg::cmd_t    head,
  input  twn_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output twn_pkg::out_t    out_data
);

  logic [twn_pkg::NL_W-1:0] sent;
  logic [twn_pkg::NL_W-1:0] prefix_len;
  logic [7:0]               prefix_ch;
  logic                     advance;
  logic                     step;
  logic                     in_prefix;
  twn_pkg::out_t            res;

  assign advance = out_ready || !out_valid;
  assign step    = advance && !q_stat.empty;

  // next result of the job at the queue head
  always_comb begin
    prefix_len = head.space ? twn_pkg::NL_W'(1) : head.nl_count;
    prefix_ch  = head.space ? twn_pkg::CH_SPACE : twn_pkg::CH_LF;
    in_prefix  = !head.is_end && (sent < prefix_len);
    if (head.is_end) begin
      res.byte_out      = 8'h00;
      res.byte_valid    = 1'b0;
      res.end_of_output = 1'b1;
    end else if (in_prefix) begin
      res.byte_out      = prefix_ch;
      res.byte_valid    = 1'b1;
      res.end_of_output = 1'b0;
    end else begin
      res.byte_out      = head.byte_val;
      res.byte_valid    = 1'b1;
      res.end_of_output = 1'b0;
    end
  end

  assign pop = step && !in_prefix;

  // output register and prefix counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sent      <= '0;
    end else if (step) begin
      out_valid <= 1'b1;
      if (in_prefix) begin
        sent <= sent + 1'b1;
      end else begin
        sent <= '0;
      end
    end else if (advance) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res;
    end
  end

endmodule

// ===== hdl/text_whitespace_normalizer.sv =====
`timescale 1ns / 1ps
// top level of the text whitespace normalizer
// depends on twn_pkg, twn_front, twn_queue, twn_back
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------
//   input   | in_valid/in_ready  | in_data  (operation, byte_in)
//   output  | out_valid/out_ready| out_data (byte_out, byte_valid, end_of_output)
//
// an input transfer is taken every cycle while the 4-entry job queue has room
// a visible byte with k pending newlines (or one pending space) gives k+1 or 2 output
// transfers at one per cycle from the back part unless out_ready stalls it; the end
// marker gives one; whitespace, cr and nul bytes queue nothing
// rst is synchronous and clears state, queue pointers and output valid at once
// a stalled output holds the back part while the front keeps filling the queue

module text_whitespace_normalizer (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  twn_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output twn_pkg::out_t out_data
);

  twn_pkg::q_stat_t q_stat;
  twn_pkg::cmd_t    push_cmd;
  twn_pkg::cmd_t    head;
  logic             push;
  logic             pop;

  // classification and state
  twn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // job queue
  twn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // result expansion
  twn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/twn_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the text whitespace normalizer, bound to the top level
// depends on twn_pkg and text_whitespace_normalizer

module twn_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input twn_pkg::out_t out_data
);

  // no output transfer offered right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // end result carries no byte
  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.end_of_output |->
      !out_data.byte_valid && (out_data.byte_out == 8'h00))
    else $error("end result carries a byte");

  // every other result carries a byte, never a removed code
  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.end_of_output |->
      out_data.byte_valid && (out_data.byte_out != twn_pkg::CH_NUL) &&
      (out_data.byte_out != twn_pkg::CH_CR) && (out_data.byte_out != twn_pkg::CH_TAB) &&
      (out_data.byte_out != twn_pkg::CH_FF) && (out_data.byte_out != twn_pkg::CH_VT))
    else $error("bad output byte");

  // stalled output transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

endmodule

bind text_whitespace_normalizer twn_checker u_twn_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
